// ===== design/blake2b_hash_assert.svh =====
// ---------------------------------------------------------------------------
// blake2b_hash assertion macros
// shared checks, written in the scope of a module with clk and rst
// ---------------------------------------------------------------------------
`ifndef BLAKE2B_HASH_ASSERT_SVH
`define BLAKE2B_HASH_ASSERT_SVH

// same-cycle implication
`define B2B_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B2B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/b2b_pkg.sv =====
// ---------------------------------------------------------------------------
// b2b_pkg
// types, constants and tables shared by the blake2b hash modules
// ---------------------------------------------------------------------------
package b2b_pkg;

  localparam int NUM_ROUNDS = 12;
  localparam logic [3:0] LAST_ROUND = 4'(NUM_ROUNDS - 1);
  localparam logic [7:0] BLOCK_BYTES = 8'd128;

  // configuration register indexes
  localparam logic [1:0] REG_OUT_LEN = 2'd0;
  localparam logic [1:0] REG_KEY_LEN = 2'd1;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } data_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [3:0]  word_bytes;
    logic        last_word;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_CHECK,
    ST_VINIT,
    ST_ROUND,
    ST_FOLD,
    ST_OUTLOAD,
    ST_OUTPUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_INSERT,
    OP_COUNT,
    OP_VINIT,
    OP_GSTEP,
    OP_FOLD,
    OP_OUTLOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       restart;
    logic       count_blk;
    logic       final_blk;
    logic       diag;
    logic       phase;
    logic [3:0] round;
  } cmd_t;

  typedef struct packed {
    logic rem_bytes;
    logic item_last;
    logic out_done;
  } sts_t;

  function automatic logic [63:0] iv(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // message schedule, one nibble per position, position 0 in the low nibble
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
    logic [63:0] row;
    case (rnd)
      4'd0, 4'd10: row = 64'hfedcba9876543210;
      4'd1, 4'd11: row = 64'h357b20c16df984ae;
      4'd2:        row = 64'h491763eadf250c8b;
      4'd3:        row = 64'h8f04a562ebcd1397;
      4'd4:        row = 64'hd386cb1efa427509;
      4'd5:        row = 64'h91ef57d438b0a6c2;
      4'd6:        row = 64'hb8293670a4def15c;
      4'd7:        row = 64'ha2684f05931ce7bd;
      4'd8:        row = 64'h5a417d2c803b9ef6;
      4'd9:        row = 64'h0dc3e9bf5167482a;
      default:     row = 64'hfedcba9876543210;
    endcase
    return row[{pos, 2'b00} +: 4];
  endfunction

  // low bytes kept, 0 to 8 of them
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    return ~(64'hffff_ffff_ffff_ffff << {n, 3'b000});
  endfunction

endpackage

// ===== design/blake2b_hash.sv =====
// ---------------------------------------------------------------------------
// blake2b_hash
// blake2b, 12 rounds, byte stream in 64-bit words, digest out as words
// ---------------------------------------------------------------------------
//  channel   | signals                        | moves
//  ----------+--------------------------------+------------------------------
//  data      | data_valid, data_stall, data   | one item: 0..8 message bytes
//  digest    | digest_valid, digest_stall,    | one item: up to 8 digest
//            | digest                         | bytes, last_word at the end
//  config    | wr_en, wr_index, wr_data       | out_len (0), key_len (1)
//
// an item that fits the buffer passes latch, insert and check
// a compression adds init, 48 half-g steps and fold; the count
// rides on the check cycle, and a split item then inserts and checks again
// the 48 steps come from four shared half-g units, two steps per mix
// a last item adds an outload step to load the digest, then 1..8 digest
// items follow; stalls hold the item
// reset and a write to either register restart the hash state
`include "blake2b_hash_assert.svh"

module blake2b_hash (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [6:0]       wr_data,
  input  logic             data_valid,
  output logic             data_stall,
  input  b2b_pkg::data_t   data,
  output logic             digest_valid,
  input  logic             digest_stall,
  output b2b_pkg::digest_t digest
);
  import b2b_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one command per cycle into the datapath
  b2b_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: buffer, counter, chain value, g units, digest register
  b2b_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .data         (data),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // no new item while a digest is still being handed out
  `B2B_ASSERT_SAME(a_no_item_during_digest, data_valid && !data_stall, !digest_valid, "item accepted during digest")

  // the final digest item ends the readout
  `B2B_ASSERT_NEXT(a_digest_ends, digest_valid && !digest_stall && digest.last_word, !digest_valid, "digest continues past last word")

  // only the last digest item may be short
  `B2B_ASSERT_SAME(a_full_words, digest_valid && !digest.last_word, digest.word_bytes == 4'd8, "short digest word before the end")

endmodule

// ===== design/b2b_ctrl.sv =====
// ---------------------------------------------------------------------------
// b2b_ctrl
// sequencer: item intake, block compression rounds and digest readout
// ---------------------------------------------------------------------------
module b2b_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          data_valid,
  output logic          data_stall,
  input  b2b_pkg::sts_t sts,
  output b2b_pkg::cmd_t cmd
);
  import b2b_pkg::*;

  state_t     state, state_next;
  logic [3:0] round, round_next;
  logic       diag, diag_next;
  logic       phase, phase_next;
  logic       final_blk, final_blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round     <= '0;
      diag      <= 1'b0;
      phase     <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      round     <= round_next;
      diag      <= diag_next;
      phase     <= phase_next;
      final_blk <= final_blk_next;
    end
  end

  always_comb begin
    state_next     = state;
    round_next     = round;
    diag_next      = diag;
    phase_next     = phase;
    final_blk_next = final_blk;
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.final_blk  = final_blk;
    cmd.diag       = diag;
    cmd.phase      = phase;
    cmd.round      = round;
    data_stall     = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (data_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.op     = OP_INSERT;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.rem_bytes) begin
          cmd.op         = OP_COUNT;
          cmd.count_blk  = 1'b1;
          final_blk_next = 1'b0;
          state_next     = ST_VINIT;
        end else if (sts.item_last) begin
          cmd.op         = OP_COUNT;
          final_blk_next = 1'b1;
          state_next     = ST_VINIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_VINIT: begin
        cmd.op     = OP_VINIT;
        round_next = '0;
        diag_next  = 1'b0;
        phase_next = 1'b0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.op     = OP_GSTEP;
        phase_next = ~phase;
        if (phase) begin
          diag_next = ~diag;
          if (diag) begin
            if (round == LAST_ROUND) state_next = ST_FOLD;
            else round_next = round + 4'd1;
          end
        end
      end
      ST_FOLD: begin
        cmd.op     = OP_FOLD;
        state_next = final_blk ? ST_OUTLOAD : ST_INSERT;
      end
      ST_OUTLOAD: begin
        cmd.op     = OP_OUTLOAD;
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (sts.out_done) begin
          cmd.restart = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/b2b_dp.sv =====
// ---------------------------------------------------------------------------
// b2b_dp
// datapath: block buffer, byte counter, chain value, four half-g units
// ---------------------------------------------------------------------------
module b2b_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [6:0]       wr_data,
  input  b2b_pkg::data_t   data,
  output b2b_pkg::digest_t digest,
  output logic             digest_valid,
  input  logic             digest_stall,
  input  b2b_pkg::cmd_t    cmd,
  output b2b_pkg::sts_t    sts
);
  import b2b_pkg::*;

  logic [6:0]   out_len, out_len_next;
  logic [6:0]   key_len, key_len_next;
  logic [63:0]  h [8];
  logic [63:0]  v [16];
  logic [63:0]  v_next [16];
  logic [63:0]  m [16];
  logic [127:0] t;
  logic [7:0]   fill;
  logic [63:0]  word_rem;
  logic [3:0]   cnt_rem;
  logic         item_last;
  logic [2:0]   k;
  logic         do_restart;
  logic [6:0]   ol_eff, kl_eff, ol_cur;
  logic [7:0]   space;
  logic [3:0]   nfit;
  logic [127:0] ins;
  logic [3:0]   widx;
  logic [2:0]   last_idx;
  logic [6:0]   rem;
  logic [3:0]   vb;
  logic         out_last;

  // register values as they stand after this edge
  always_comb begin
    out_len_next = out_len;
    key_len_next = key_len;
    if (rst) begin
      out_len_next = 7'd64;
      key_len_next = 7'd0;
    end else if (wr_en && wr_index == REG_OUT_LEN) begin
      out_len_next = wr_data;
    end else if (wr_en && wr_index == REG_KEY_LEN) begin
      key_len_next = wr_data;
    end
    ol_eff = (out_len_next == 7'd0) ? 7'd1 : ((out_len_next > 7'd64) ? 7'd64 : out_len_next);
    kl_eff = (key_len_next > 7'd64) ? 7'd64 : key_len_next;
  end

  assign do_restart = rst || cmd.restart ||
                      (wr_en && (wr_index == REG_OUT_LEN || wr_index == REG_KEY_LEN));

  // byte insertion
  always_comb begin
    space = BLOCK_BYTES - fill;
    nfit  = ({4'd0, cnt_rem} > space) ? space[3:0] : cnt_rem;
    ins   = {64'd0, word_rem & byte_mask(nfit)} << {fill[2:0], 3'b000};
    widx  = fill[6:3];
  end

  // four half-g units, column or diagonal step
  always_comb begin
    logic [1:0]  uu;
    logic [3:0]  ia, ib, ic, id;
    logic [63:0] a, b, c, d, x, a1, d0, d1, c1, b0, b1;
    for (int i = 0; i < 16; i++) v_next[i] = v[i];
    for (int u = 0; u < 4; u++) begin
      uu = 2'(u);
      ia = {2'b00, uu};
      ib = {2'b01, cmd.diag ? uu + 2'd1 : uu};
      ic = {2'b10, cmd.diag ? uu + 2'd2 : uu};
      id = {2'b11, cmd.diag ? uu + 2'd3 : uu};
      a  = v[ia];
      b  = v[ib];
      c  = v[ic];
      d  = v[id];
      x  = m[sigma(cmd.round, {cmd.diag, uu, cmd.phase})];
      a1 = a + b + x;
      d0 = d ^ a1;
      d1 = cmd.phase ? {d0[15:0], d0[63:16]} : {d0[31:0], d0[63:32]};
      c1 = c + d1;
      b0 = b ^ c1;
      b1 = cmd.phase ? {b0[62:0], b0[63]} : {b0[23:0], b0[63:24]};
      v_next[ia] = a1;
      v_next[ib] = b1;
      v_next[ic] = c1;
      v_next[id] = d1;
    end
  end

  always_ff @(posedge clk) begin
    out_len <= out_len_next;
    key_len <= key_len_next;
    if (do_restart) begin
      for (int i = 1; i < 8; i++) h[i] <= iv(3'(i));
      h[0]  <= iv(3'd0) ^ {32'd0, 16'h0101, 1'b0, kl_eff, 1'b0, ol_eff};
      t     <= '0;
      for (int i = 0; i < 16; i++) m[i] <= '0;
      fill  <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          word_rem  <= data.data_word;
          cnt_rem   <= (data.byte_count > 4'd8) ? 4'd8 : data.byte_count;
          item_last <= data.last;
        end
        OP_INSERT: begin
          if (nfit != 4'd0) begin
            m[widx] <= m[widx] | ins[63:0];
            if (widx != 4'd15) m[widx + 4'd1] <= m[widx + 4'd1] | ins[127:64];
          end
          word_rem <= word_rem >> {nfit, 3'b000};
          cnt_rem  <= cnt_rem - nfit;
          fill     <= fill + {4'd0, nfit};
        end
        OP_COUNT: begin
          t <= t + {120'd0, cmd.count_blk ? BLOCK_BYTES : fill};
        end
        OP_VINIT: begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          for (int i = 0; i < 4; i++) v[8 + i] <= iv(3'(i));
          v[12] <= iv(3'd4) ^ t[63:0];
          v[13] <= iv(3'd5) ^ t[127:64];
          v[14] <= iv(3'd6) ^ {64{cmd.final_blk}};
          v[15] <= iv(3'd7);
        end
        OP_GSTEP: begin
          for (int i = 0; i < 16; i++) v[i] <= v_next[i];
        end
        OP_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[i + 8];
          for (int i = 0; i < 16; i++) m[i] <= '0;
          fill <= '0;
        end
        default: ;
      endcase
    end
  end

  // digest readout
  always_comb begin
    ol_cur   = (out_len == 7'd0) ? 7'd1 : ((out_len > 7'd64) ? 7'd64 : out_len);
    last_idx = 3'((ol_cur - 7'd1) >> 3);
    rem      = ol_cur - {1'b0, k, 3'b000};
    vb       = (rem > 7'd8) ? 4'd8 : rem[3:0];
    out_last = (k == last_idx);
    digest.digest_word = h[k] & byte_mask(vb);
    digest.word_bytes  = vb;
    digest.last_word   = out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
      k            <= '0;
    end else if (cmd.op == OP_OUTLOAD) begin
      digest_valid <= 1'b1;
      k            <= '0;
    end else if (digest_valid && !digest_stall) begin
      if (out_last) digest_valid <= 1'b0;
      else k <= k + 3'd1;
    end
  end

  assign sts.rem_bytes = (cnt_rem != 4'd0);
  assign sts.item_last = item_last;
  assign sts.out_done  = digest_valid && !digest_stall && out_last;

endmodule
